// ===== src/rgbob_pkg.sv =====
package rgbob_pkg;

	// pixel format codes held in the format register
	localparam logic [2:0] FMT_RGBA8 = 3'd0;
	localparam logic [2:0] FMT_RGB8  = 3'd1;
	localparam logic [2:0] FMT_RG48  = 3'd2;
	localparam logic [2:0] FMT_R10K  = 3'd3;
	localparam logic [2:0] FMT_R12L  = 3'd4;

	localparam int FMT_W     = 3;
	localparam int COMP_W    = 16;
	localparam int CHUNK_W   = 96;
	localparam int NUM_LANES = 8;

	// component depth of one blend lane
	typedef enum logic [1:0] {
		DEP_8,
		DEP_10,
		DEP_12,
		DEP_16
	} depth_t;

	// operands of one blend lane: overlay value, destination value, alpha
	typedef struct packed {
		logic [COMP_W-1:0] s;
		logic [COMP_W-1:0] d;
		logic [COMP_W-1:0] a;
		depth_t            dep;
	} lane_op_t;

	// input request payload, first field in the highest bits
	typedef struct packed {
		logic [31:0]       dst_high;
		logic [63:0]       dst_low;
		logic [COMP_W-1:0] ov_alpha1;
		logic [COMP_W-1:0] ov_blue1;
		logic [COMP_W-1:0] ov_green1;
		logic [COMP_W-1:0] ov_red1;
		logic [COMP_W-1:0] ov_alpha0;
		logic [COMP_W-1:0] ov_blue0;
		logic [COMP_W-1:0] ov_green0;
		logic [COMP_W-1:0] ov_red0;
	} item_t;

	localparam int ITEM_W = $bits(item_t);

endpackage

// ===== src/rgbob_unpack.sv =====
module rgbob_unpack (
	input  rgbob_pkg::item_t                                item,
	input  logic [rgbob_pkg::FMT_W-1:0]                     fmt,
	output rgbob_pkg::lane_op_t [rgbob_pkg::NUM_LANES-1:0]  ops
);
	import rgbob_pkg::*;

	function automatic lane_op_t mk_op(logic [COMP_W-1:0] s, logic [COMP_W-1:0] d,
			logic [COMP_W-1:0] a, depth_t dep);
		lane_op_t o;
		o.s   = s;
		o.d   = d;
		o.a   = a;
		o.dep = dep;
		return o;
	endfunction

	logic [CHUNK_W-1:0] chunk;
	logic [COMP_W-1:0]  px0 [4];
	logic [COMP_W-1:0]  px1 [4];
	logic [31:0]        w0;
	logic [31:0]        w1;

	assign chunk = {item.dst_high, item.dst_low};
	assign w0    = chunk[31:0];
	assign w1    = chunk[63:32];

	always_comb begin
		px0[0] = item.ov_red0;
		px0[1] = item.ov_green0;
		px0[2] = item.ov_blue0;
		px0[3] = item.ov_alpha0;
		px1[0] = item.ov_red1;
		px1[1] = item.ov_green1;
		px1[2] = item.ov_blue1;
		px1[3] = item.ov_alpha1;
	end

	always_comb begin
		ops = '0;
		case (fmt)
			FMT_RGBA8: begin
				for (int c = 0; c < 3; c++) begin
					ops[c]   = mk_op({8'd0, px0[c][15:8]}, {8'd0, chunk[8*c +: 8]},
						{8'd0, px0[3][15:8]}, DEP_8);
					ops[4+c] = mk_op({8'd0, px1[c][15:8]}, {8'd0, chunk[8*(4+c) +: 8]},
						{8'd0, px1[3][15:8]}, DEP_8);
				end
				// alpha byte: over with a full-scale source gives a + d*(255-a)/255
				ops[3] = mk_op(16'd255, {8'd0, chunk[31:24]}, {8'd0, px0[3][15:8]}, DEP_8);
				ops[7] = mk_op(16'd255, {8'd0, chunk[63:56]}, {8'd0, px1[3][15:8]}, DEP_8);
			end
			FMT_RGB8: begin
				for (int c = 0; c < 3; c++) begin
					ops[c]   = mk_op({8'd0, px0[c][15:8]}, {8'd0, chunk[8*c +: 8]},
						{8'd0, px0[3][15:8]}, DEP_8);
					ops[4+c] = mk_op({8'd0, px1[c][15:8]}, {8'd0, chunk[8*(3+c) +: 8]},
						{8'd0, px1[3][15:8]}, DEP_8);
				end
			end
			FMT_RG48: begin
				for (int c = 0; c < 3; c++) begin
					ops[c]   = mk_op(px0[c], chunk[16*c +: 16], px0[3], DEP_16);
					ops[4+c] = mk_op(px1[c], chunk[48+16*c +: 16], px1[3], DEP_16);
				end
			end
			FMT_R10K: begin
				ops[0] = mk_op({6'd0, px0[0][15:6]}, {6'd0, w0[7:0], w0[15:14]},
					{6'd0, px0[3][15:6]}, DEP_10);
				ops[1] = mk_op({6'd0, px0[1][15:6]}, {6'd0, w0[13:8], w0[23:20]},
					{6'd0, px0[3][15:6]}, DEP_10);
				ops[2] = mk_op({6'd0, px0[2][15:6]}, {6'd0, w0[19:16], w0[31:26]},
					{6'd0, px0[3][15:6]}, DEP_10);
				ops[4] = mk_op({6'd0, px1[0][15:6]}, {6'd0, w1[7:0], w1[15:14]},
					{6'd0, px1[3][15:6]}, DEP_10);
				ops[5] = mk_op({6'd0, px1[1][15:6]}, {6'd0, w1[13:8], w1[23:20]},
					{6'd0, px1[3][15:6]}, DEP_10);
				ops[6] = mk_op({6'd0, px1[2][15:6]}, {6'd0, w1[19:16], w1[31:26]},
					{6'd0, px1[3][15:6]}, DEP_10);
			end
			FMT_R12L: begin
				// 12-bit samples sit back to back in the low 72 bits
				for (int c = 0; c < 3; c++) begin
					ops[c]   = mk_op({4'd0, px0[c][15:4]}, {4'd0, chunk[12*c +: 12]},
						{4'd0, px0[3][15:4]}, DEP_12);
					ops[4+c] = mk_op({4'd0, px1[c][15:4]}, {4'd0, chunk[36+12*c +: 12]},
						{4'd0, px1[3][15:4]}, DEP_12);
				end
			end
			default: begin
				ops = '0;
			end
		endcase
	end

endmodule

// ===== src/rgbob_mix.sv =====
module rgbob_mix (
	input  rgbob_pkg::lane_op_t          op,
	output logic [rgbob_pkg::COMP_W-1:0] q
);
	import rgbob_pkg::*;

	logic [4:0]         sh;
	logic signed [16:0] diff;
	logic signed [33:0] prod;
	logic [32:0]        d_sh;
	logic [32:0]        d_max;
	logic signed [33:0] num_full;
	logic [31:0]        num;
	logic [31:0]        num_hi;
	logic [32:0]        t;
	logic [32:0]        t_sh;

	always_comb begin
		case (op.dep)
			DEP_8:   sh = 5'd8;
			DEP_10:  sh = 5'd10;
			DEP_12:  sh = 5'd12;
			DEP_16:  sh = 5'd16;
			default: sh = 5'd8;
		endcase
	end

	// s*a + d*(max-a) rewritten as d*max + (s-d)*a: one multiply
	assign diff     = $signed({1'b0, op.s}) - $signed({1'b0, op.d});
	assign prod     = diff * $signed({1'b0, op.a});
	assign d_sh     = {17'd0, op.d} << sh;
	assign d_max    = d_sh - {17'd0, op.d};
	assign num_full = $signed({1'b0, d_max}) + prod;
	assign num      = num_full[31:0];

	// floor(x / (2^n - 1)) for x <= (2^n - 1)^2 as (x + (x >> n) + 1) >> n
	assign num_hi = num >> sh;
	assign t      = {1'b0, num} + {1'b0, num_hi} + 33'd1;
	assign t_sh   = t >> sh;
	assign q      = t_sh[COMP_W-1:0];

endmodule

// ===== src/rgbob_pack.sv =====
module rgbob_pack (
	input  logic [rgbob_pkg::CHUNK_W-1:0]                      chunk,
	input  logic [rgbob_pkg::NUM_LANES-1:0][rgbob_pkg::COMP_W-1:0] q,
	input  logic [rgbob_pkg::FMT_W-1:0]                        fmt,
	input  logic                                               both,
	output logic [rgbob_pkg::CHUNK_W-1:0]                      res
);
	import rgbob_pkg::*;

	// r10k word from three 10-bit components, pad bits set
	function automatic logic [31:0] r10k_word(logic [9:0] r, logic [9:0] g, logic [9:0] b);
		return {b[5:0], 2'b11, g[3:0], b[9:6], r[1:0], g[9:4], r[9:2]};
	endfunction

	always_comb begin
		res = chunk;
		case (fmt)
			FMT_RGBA8: begin
				for (int c = 0; c < 4; c++) begin
					res[8*c +: 8] = q[c][7:0];
					if (both) begin
						res[8*(4+c) +: 8] = q[4+c][7:0];
					end
				end
			end
			FMT_RGB8: begin
				for (int c = 0; c < 3; c++) begin
					res[8*c +: 8] = q[c][7:0];
					if (both) begin
						res[8*(3+c) +: 8] = q[4+c][7:0];
					end
				end
			end
			FMT_RG48: begin
				for (int c = 0; c < 3; c++) begin
					res[16*c +: 16] = q[c];
					if (both) begin
						res[48+16*c +: 16] = q[4+c];
					end
				end
			end
			FMT_R10K: begin
				res[31:0] = r10k_word(q[0][9:0], q[1][9:0], q[2][9:0]);
				if (both) begin
					res[63:32] = r10k_word(q[4][9:0], q[5][9:0], q[6][9:0]);
				end
			end
			FMT_R12L: begin
				// lone pixel is dropped in this format
				if (both) begin
					res[71:0] = {q[6][11:0], q[5][11:0], q[4][11:0],
						q[2][11:0], q[1][11:0], q[0][11:0]};
				end
			end
			default: begin
				res = chunk;
			end
		endcase
	end

endmodule

// ===== src/rgb_overlay_alpha_blender_core.sv =====
// Blends a pair of 16-bit RGBA overlay pixels into a 12-byte little-endian destination
// chunk, one pair per clock while the output is not stalled: each request is latched
// into an input register, blended by eight parallel lanes (one multiply and a shift-add
// divide by 2^n-1 each) and captured in an output register that offers the result; while
// a result waits, the input register can still take one more request. The format
// register (0 rgba8, 1 rgb8, 2 rg48, 3 r10k, 4 r12l, other codes pass the chunk
// through) must only be written while no request is in flight. Overlay values are
// truncated to the format depth; destination bytes outside the format pass through.
// With one_pixel set only the first pixel is blended, and in r12l the chunk is
// returned unchanged.
module rgb_overlay_alpha_blender_core (
	input  logic                                clk,
	input  logic                                arst_n,
	// ov_red0, ov_green0, ov_blue0, ov_alpha0, ov_red1, ov_green1, ov_blue1,
	// ov_alpha1 (16 bits each), dst_low (64), dst_high (32)
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [rgbob_pkg::ITEM_W-1:0]        s_axis_tdata,
	// one_pixel
	input  logic [0:0]                          s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// out_low (64), out_high (32)
	output logic [rgbob_pkg::CHUNK_W-1:0]       m_axis_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [rgbob_pkg::FMT_W-1:0]         cfg_data
);
	import rgbob_pkg::*;

	logic [FMT_W-1:0]   pixel_format_q;

	// input stage
	logic               valid_s1;
	item_t              item_s1;
	logic               one_pixel_s1;

	// output stage
	logic               valid_s2;
	logic [CHUNK_W-1:0] res_s2;

	logic               ready_s2;
	logic [CHUNK_W-1:0] chunk;
	logic [CHUNK_W-1:0] res;
	lane_op_t [NUM_LANES-1:0]             ops;
	logic [NUM_LANES-1:0][COMP_W-1:0]     lane_q;

	// format register, writes always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_format_q <= FMT_RGBA8;
		end else if (cfg_valid && cfg_ready) begin
			pixel_format_q <= cfg_data;
		end
	end

	// stage 2 frees when empty or drained; stage 1 frees when it moves on
	assign ready_s2      = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1      <= item_t'(s_axis_tdata);
			one_pixel_s1 <= s_axis_tuser[0];
		end
		if (valid_s1 && ready_s2) begin
			res_s2 <= res;
		end
	end

	assign chunk = {item_s1.dst_high, item_s1.dst_low};

	// map the chunk and overlay onto blend lanes for the current format
	rgbob_unpack u_unpack (
		.item (item_s1),
		.fmt  (pixel_format_q),
		.ops  (ops)
	);

	// lanes 0..3 serve the first pixel, lanes 4..7 the second
	for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
		rgbob_mix u_mix (
			.op (ops[i]),
			.q  (lane_q[i])
		);
	end

	// write lane results back into the chunk, untouched bytes pass through
	rgbob_pack u_pack (
		.chunk (chunk),
		.q     (lane_q),
		.fmt   (pixel_format_q),
		.both  (!one_pixel_s1),
		.res   (res)
	);

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = res_s2;

	// a request leaving the input stage always lands in the output stage
	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && ready_s2 |=> valid_s2)
		else $error("request lost between input and output stage");

	// input only backs up when both stages hold requests and the sink stalls
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s1 && valid_s2 && !m_axis_tready)
		else $error("input stalled with room in the pipeline");

	// an accepted request is held in the input stage the next cycle
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> valid_s1)
		else $error("accepted request not captured");

	// unknown formats return the destination chunk unchanged
	a_unknown_pass: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && ready_s2 && (pixel_format_q > FMT_R12L)
		|=> res_s2 == $past(chunk))
		else $error("unknown format altered the chunk");

endmodule
